// File: rtl/cfa_pkg.sv
// shared types, codes and defaults for the contiguous fit allocator
package cfa_pkg;

   // default sizing
   localparam int MEM_UNITS_DEF = 256;
   localparam int ID_BITS_DEF   = 8;

   // fixed field widths
   localparam int SIZE_W   = 9;
   localparam int ID_FLD_W = 8;
   localparam int UNIT_W   = 8;
   localparam int FREED_W  = 9;
   localparam int MSIZE_W  = 9;

   // memory_size after reset
   localparam logic [MSIZE_W-1:0] MSIZE_RESET = 9'd256;

   // request kinds
   localparam logic MODE_ALLOC   = 1'b0;
   localparam logic MODE_RELEASE = 1'b1;

   // placement policies
   typedef enum logic [1:0] {
      POL_FIRST   = 2'd0,
      POL_BEST    = 2'd1,
      POL_WORST   = 2'd2,
      POL_INVALID = 2'd3
   } policy_type;

   // response status codes
   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_NOFIT   = 2'd1,
      ST_POLICY  = 2'd2,
      ST_NO_IDS  = 2'd3
   } status_type;

   // control handed to the hole compare unit
   typedef struct packed {
      policy_type policy;
      logic       found;
   } fit_ctl_type;

endpackage

// File: rtl/cfa_ram.sv
// generic simple dual-port ram with registered read
module cfa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/cfa_fit_unit.sv
// hole compare unit: decides whether a closed free run becomes the new candidate
module cfa_fit_unit
   import cfa_pkg::*;
#(
   parameter int LEN_W = 9
) (
   input  fit_ctl_type      ctl,
   input  logic [LEN_W-1:0] run_len,
   input  logic [LEN_W-1:0] best_len,
   input  logic [LEN_W-1:0] req_size,
   output logic             take
);

   logic fits;

   assign fits = (run_len >= req_size);

   // policy selection, ties keep the earlier run
   always_comb begin
      case (ctl.policy)
         POL_FIRST: take = fits && !ctl.found;
         POL_BEST:  take = fits && (!ctl.found || (run_len < best_len));
         default:   take = !ctl.found || (run_len > best_len);
      endcase
   end

endmodule

// File: rtl/contiguous_fit_allocator_unit.sv
// top level: owner map, scan sequencer and response register of the fit allocator
//
// Keeps an owner id per memory unit (0 = free) in a ram and serves one request at
// a time. After reset a clearing pass writes zero to all MEM_UNITS entries, one a
// cycle, before the first request is taken (csr writes are taken throughout). An
// allocate request walks the managed units through the ram read port once, one unit
// per cycle, feeding each closed free run to the hole compare unit; it then marks
// the granted units one per cycle. The managed units number min(memory_size,
// MEM_UNITS). A release walks the units once, clearing matches through the write
// port. Invalid policy or exhausted ids are answered without a walk. The response
// sits in an output register, so a new request is taken while the previous
// response waits.
module contiguous_fit_allocator_unit
   import cfa_pkg::*;
#(
   parameter int MEM_UNITS = MEM_UNITS_DEF,
   parameter int ID_BITS   = ID_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   // request channel
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_mode,
   input  logic [SIZE_W-1:0]    req_request_size,
   input  logic [1:0]           req_policy,
   input  logic [ID_FLD_W-1:0]  req_release_id,
   // response channel
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [1:0]           rsp_status,
   output logic [UNIT_W-1:0]    rsp_start_unit,
   output logic [ID_FLD_W-1:0]  rsp_owner_id,
   output logic [FREED_W-1:0]   rsp_freed_units,
   // configuration
   input  logic                 csr_wr_en,
   input  logic [MSIZE_W-1:0]   csr_wr_data
);

   localparam int AW    = $clog2(MEM_UNITS);
   localparam int CNT_W = $clog2(MEM_UNITS + 1);
   localparam int LEN_W = (CNT_W > SIZE_W) ? CNT_W : SIZE_W;
   localparam int OW    = (ID_BITS > ID_FLD_W) ? ID_BITS : ID_FLD_W;
   localparam int SW    = (CNT_W > UNIT_W) ? CNT_W : UNIT_W;

   typedef enum logic [6:0] {
      S_CLEAR   = 7'b0000001,
      S_IDLE    = 7'b0000010,
      S_SCAN    = 7'b0000100,
      S_DECIDE  = 7'b0001000,
      S_MARK    = 7'b0010000,
      S_RELEASE = 7'b0100000,
      S_FINISH  = 7'b1000000
   } state_type;

   // registers and next values
   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 iss_ff, iss_in;
   logic                 p_valid_ff, p_valid_in;
   logic [CNT_W-1:0]     p_pos_ff, p_pos_in;
   logic [CNT_W-1:0]     units_ff, units_in;
   logic                 mode_ff, mode_in;
   logic [SIZE_W-1:0]    size_ff, size_in;
   policy_type           policy_ff, policy_in;
   logic [ID_FLD_W-1:0]  rel_ff, rel_in;
   logic [ID_BITS-1:0]   next_id_ff, next_id_in;
   logic [CNT_W-1:0]     run_len_ff, run_len_in;
   logic [CNT_W-1:0]     run_start_ff, run_start_in;
   logic                 found_ff, found_in;
   logic [CNT_W-1:0]     best_len_ff, best_len_in;
   logic [CNT_W-1:0]     best_start_ff, best_start_in;
   logic [SIZE_W-1:0]    left_ff, left_in;
   status_type           status_ff, status_in;
   logic                 grant_ff, grant_in;
   logic [CNT_W-1:0]     freed_ff, freed_in;
   logic [MSIZE_W-1:0]   msize_ff, msize_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [1:0]           rsp_status_ff, rsp_status_in;
   logic [UNIT_W-1:0]    rsp_start_ff, rsp_start_in;
   logic [ID_FLD_W-1:0]  rsp_owner_ff, rsp_owner_in;
   logic [FREED_W-1:0]   rsp_freed_ff, rsp_freed_in;

   // ram ports
   logic                 ram_we;
   logic [AW-1:0]        ram_waddr;
   logic [ID_BITS-1:0]   ram_wdata;
   logic [ID_BITS-1:0]   ram_rdata;

   // helpers
   logic                 req_accept;
   logic                 slot_free;
   logic [LEN_W-1:0]     msize_ext;
   logic [LEN_W-1:0]     units_cur;
   logic                 p_inrange;
   logic                 p_free;
   logic                 p_match;
   logic                 p_close;
   logic [LEN_W-1:0]     size_ext;
   logic                 take;
   fit_ctl_type          fit_ctl;
   logic [OW-1:0]        id_ext;
   logic [SW-1:0]        start_ext;
   logic [LEN_W-1:0]     freed_ext;

   cfa_ram #(
      .WIDTH (ID_BITS),
      .DEPTH (MEM_UNITS)
   ) u_owner_map (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (cnt_ff[AW-1:0]),
      .rd_data (ram_rdata)
   );

   // managed unit count
   assign msize_ext = LEN_W'(msize_ff);
   assign units_cur = (msize_ext < LEN_W'(MEM_UNITS)) ? msize_ext : LEN_W'(MEM_UNITS);

   // handshake
   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign slot_free  = !rsp_valid_ff || !rsp_stall;

   // unit coming back from the ram
   assign p_inrange = (p_pos_ff < units_ff);
   assign p_free    = p_inrange && (ram_rdata == '0);
   assign p_match   = p_inrange && (rel_ff != '0) && (OW'(ram_rdata) == OW'(rel_ff));
   assign p_close   = p_valid_ff && (p_pos_ff == units_ff);

   // hole compare unit
   assign size_ext       = LEN_W'(size_ff);
   assign fit_ctl.policy = policy_ff;
   assign fit_ctl.found  = found_ff;

   cfa_fit_unit #(
      .LEN_W (LEN_W)
   ) u_fit (
      .ctl      (fit_ctl),
      .run_len  (LEN_W'(run_len_ff)),
      .best_len (LEN_W'(best_len_ff)),
      .req_size (size_ext),
      .take     (take)
   );

   // response field shaping
   assign id_ext    = OW'(next_id_ff);
   assign start_ext = SW'(best_start_ff);
   assign freed_ext = LEN_W'(freed_ff);

   // ram write port selection
   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = cnt_ff[AW-1:0];
      ram_wdata = '0;
      case (state_ff)
         S_CLEAR: begin
            ram_we = 1'b1;
         end
         S_RELEASE: begin
            ram_we    = p_valid_ff && p_match;
            ram_waddr = p_pos_ff[AW-1:0];
         end
         S_MARK: begin
            ram_we    = (left_ff != '0);
            ram_wdata = next_id_ff;
         end
         default: begin
            ram_we = 1'b0;
         end
      endcase
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      iss_in        = 1'b0;
      p_valid_in    = 1'b0;
      p_pos_in      = cnt_ff;
      units_in      = units_ff;
      mode_in       = mode_ff;
      size_in       = size_ff;
      policy_in     = policy_ff;
      rel_in        = rel_ff;
      next_id_in    = next_id_ff;
      run_len_in    = run_len_ff;
      run_start_in  = run_start_ff;
      found_in      = found_ff;
      best_len_in   = best_len_ff;
      best_start_in = best_start_ff;
      left_in       = left_ff;
      status_in     = status_ff;
      grant_in      = grant_ff;
      freed_in      = freed_ff;
      msize_in      = csr_wr_en ? csr_wr_data : msize_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_start_in  = rsp_start_ff;
      rsp_owner_in  = rsp_owner_ff;
      rsp_freed_in  = rsp_freed_ff;

      // read issue shared by scan and release
      if ((state_ff == S_SCAN) || (state_ff == S_RELEASE)) begin
         if (iss_ff) begin
            p_valid_in = 1'b1;
            p_pos_in   = cnt_ff;
            if (cnt_ff == units_ff) begin
               iss_in = 1'b0;
            end else begin
               iss_in = 1'b1;
               cnt_in = cnt_ff + 1'b1;
            end
         end
      end

      case (state_ff)
         // zero the owner map after reset
         S_CLEAR: begin
            if (cnt_ff == CNT_W'(MEM_UNITS - 1)) begin
               state_in = S_IDLE;
               cnt_in   = '0;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end

         // take a request
         S_IDLE: begin
            if (req_accept) begin
               mode_in       = req_mode;
               size_in       = req_request_size;
               policy_in     = policy_type'(req_policy);
               rel_in        = req_release_id;
               units_in      = units_cur[CNT_W-1:0];
               cnt_in        = '0;
               status_in     = ST_OK;
               grant_in      = 1'b0;
               freed_in      = '0;
               run_len_in    = '0;
               run_start_in  = '0;
               found_in      = 1'b0;
               best_len_in   = '0;
               best_start_in = '0;
               if (req_mode == MODE_RELEASE) begin
                  state_in = S_RELEASE;
                  iss_in   = 1'b1;
               end else if (policy_type'(req_policy) == POL_INVALID) begin
                  status_in = ST_POLICY;
                  state_in  = S_FINISH;
               end else if (&next_id_ff) begin
                  status_in = ST_NO_IDS;
                  state_in  = S_FINISH;
               end else begin
                  next_id_in = next_id_ff + 1'b1;
                  state_in   = S_SCAN;
                  iss_in     = 1'b1;
               end
            end
         end

         // walk the units and track free runs
         S_SCAN: begin
            if (p_valid_ff) begin
               if (p_free) begin
                  if (run_len_ff == '0) begin
                     run_start_in = p_pos_ff;
                  end
                  run_len_in = run_len_ff + 1'b1;
               end else begin
                  if ((run_len_ff != '0) && take) begin
                     found_in      = 1'b1;
                     best_len_in   = run_len_ff;
                     best_start_in = run_start_ff;
                  end
                  run_len_in = '0;
               end
               if (p_close) begin
                  state_in = S_DECIDE;
               end
            end
         end

         // grant or refuse
         S_DECIDE: begin
            if (found_ff && (LEN_W'(best_len_ff) >= size_ext)) begin
               grant_in = 1'b1;
               cnt_in   = best_start_ff;
               left_in  = size_ff;
               state_in = S_MARK;
            end else begin
               status_in = ST_NOFIT;
               state_in  = S_FINISH;
            end
         end

         // write the new owner over the granted units
         S_MARK: begin
            if (left_ff != '0) begin
               cnt_in  = cnt_ff + 1'b1;
               left_in = left_ff - 1'b1;
            end else begin
               state_in = S_FINISH;
            end
         end

         // free the owner's units
         S_RELEASE: begin
            if (p_valid_ff) begin
               if (p_match) begin
                  freed_in = freed_ff + 1'b1;
               end
               if (p_close) begin
                  state_in = S_FINISH;
               end
            end
         end

         // load the response register once it is free
         S_FINISH: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_start_in  = grant_ff ? start_ext[UNIT_W-1:0] : '0;
               rsp_owner_in  = grant_ff ? id_ext[ID_FLD_W-1:0] : '0;
               rsp_freed_in  = (mode_ff == MODE_RELEASE) ? freed_ext[FREED_W-1:0] : '0;
               state_in      = S_IDLE;
               cnt_in        = '0;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         cnt_ff       <= '0;
         iss_ff       <= 1'b0;
         p_valid_ff   <= 1'b0;
         next_id_ff   <= '0;
         msize_ff     <= MSIZE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         iss_ff       <= iss_in;
         p_valid_ff   <= p_valid_in;
         next_id_ff   <= next_id_in;
         msize_ff     <= msize_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      p_pos_ff      <= p_pos_in;
      units_ff      <= units_in;
      mode_ff       <= mode_in;
      size_ff       <= size_in;
      policy_ff     <= policy_in;
      rel_ff        <= rel_in;
      run_len_ff    <= run_len_in;
      run_start_ff  <= run_start_in;
      found_ff      <= found_in;
      best_len_ff   <= best_len_in;
      best_start_ff <= best_start_in;
      left_ff       <= left_in;
      status_ff     <= status_in;
      grant_ff      <= grant_in;
      freed_ff      <= freed_in;
      rsp_status_ff <= rsp_status_in;
      rsp_start_ff  <= rsp_start_in;
      rsp_owner_ff  <= rsp_owner_in;
      rsp_freed_ff  <= rsp_freed_in;
   end

   // outputs
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_start_unit  = rsp_start_ff;
   assign rsp_owner_id    = rsp_owner_ff;
   assign rsp_freed_units = rsp_freed_ff;

endmodule

// File: verif/tb_contiguous_fit_allocator_unit.sv
// self-checking testbench for the contiguous fit allocator unit
`timescale 1ns / 100ps

module tb_contiguous_fit_allocator_unit
   import cfa_pkg::*;
();

   localparam int ID_LIMIT        = (1 << ID_BITS_DEF) - 1;
   localparam int CYCLE_LIMIT     = 3000000;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int ITEMS_PER_PHASE = 90;
   localparam int REPORT_LIMIT    = 10;
   localparam int SETTLE_CYCLES   = 16;

   // one expected or observed response
   typedef struct packed {
      status_type              status;
      logic [UNIT_W-1:0]       start_unit;
      logic [ID_FLD_W-1:0]     owner_id;
      logic [FREED_W-1:0]      freed_units;
   } alloc_reply_type;

   // receiver stall behaviors
   typedef enum logic [1:0] {
      STALL_NONE     = 2'd0,
      STALL_LIGHT    = 2'd1,
      STALL_HEAVY    = 2'd2,
      STALL_PERIODIC = 2'd3
   } stall_pattern_type;

   // dut signals
   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic                 req_mode = MODE_ALLOC;
   logic [SIZE_W-1:0]    req_request_size = '0;
   policy_type           req_policy = POL_FIRST;
   logic [ID_FLD_W-1:0]  req_release_id = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [1:0]           rsp_status;
   logic [UNIT_W-1:0]    rsp_start_unit;
   logic [ID_FLD_W-1:0]  rsp_owner_id;
   logic [FREED_W-1:0]   rsp_freed_units;
   logic                 csr_wr_en = 1'b0;
   logic [MSIZE_W-1:0]   csr_wr_data = '0;

   // predictor state
   logic [ID_BITS_DEF-1:0] owner_map [MEM_UNITS_DEF];
   int                     next_owner_id = 0;
   int                     managed_size = MSIZE_RESET;

   // expected responses and bookkeeping
   alloc_reply_type   pending_replies [$];
   alloc_reply_type   last_reply;
   alloc_reply_type   expected_reply;
   logic [7:0]        live_owners [$];
   int                burst_left = 0;
   int                cycle_count = 0;
   int                mismatch_count = 0;
   int                total_requests = 0;
   int                grant_count = 0;
   int                nofit_count = 0;
   int                policy_reject_count = 0;
   int                exhausted_count = 0;
   int                release_count = 0;
   int                freed_total = 0;

   // receiver stall control
   stall_pattern_type stall_pattern = STALL_NONE;
   int                pattern_left = 0;
   int                stall_phase = 0;
   int                hold_left = 0;
   bit                hold_off_pending = 1'b0;

   contiguous_fit_allocator_unit u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_mode         (req_mode),
      .req_request_size (req_request_size),
      .req_policy       (req_policy),
      .req_release_id   (req_release_id),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_start_unit   (rsp_start_unit),
      .rsp_owner_id     (rsp_owner_id),
      .rsp_freed_units  (rsp_freed_units),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_contiguous_fit_allocator_unit failed");
         $finish;
      end
   end

   // allocator behavior: updates the owner map and returns the response
   function automatic alloc_reply_type predict_reply(input logic mode,
                                                     input logic [SIZE_W-1:0] size,
                                                     input policy_type policy,
                                                     input logic [ID_FLD_W-1:0] rel);
      alloc_reply_type r;
      int  units;
      int  freed;
      int  u;
      int  run_start;
      int  run_len;
      int  best_start;
      int  best_len;
      bit  found;
      bit  fits;
      bit  take;
      r          = '0;
      freed      = 0;
      run_start  = 0;
      run_len    = 0;
      best_start = 0;
      best_len   = 0;
      found      = 1'b0;
      units      = (managed_size < MEM_UNITS_DEF) ? managed_size : MEM_UNITS_DEF;
      if (mode == MODE_RELEASE) begin
         if (rel != 0) begin
            for (u = 0; u < units; u++) begin
               if (owner_map[u] == rel) begin
                  owner_map[u] = '0;
                  freed++;
               end
            end
         end
         r.freed_units = FREED_W'(freed);
      end else if (policy == POL_INVALID) begin
         r.status = ST_POLICY;
      end else if (next_owner_id >= ID_LIMIT) begin
         r.status = ST_NO_IDS;
      end else begin
         next_owner_id++;
         // walk the units, one extra step closes a trailing run
         for (u = 0; u <= units; u++) begin
            if (u < units && owner_map[u] == 0) begin
               if (run_len == 0) run_start = u;
               run_len++;
            end else begin
               if (run_len != 0) begin
                  fits = (run_len >= size);
                  case (policy)
                     POL_FIRST: take = fits && !found;
                     POL_BEST:  take = fits && (!found || run_len < best_len);
                     default:   take = !found || run_len > best_len;
                  endcase
                  if (take) begin
                     found      = 1'b1;
                     best_start = run_start;
                     best_len   = run_len;
                  end
               end
               run_len = 0;
            end
         end
         if (found && best_len >= size) begin
            for (u = best_start; u < best_start + size && u < units; u++)
               owner_map[u] = ID_BITS_DEF'(next_owner_id);
            r.start_unit = UNIT_W'(best_start);
            r.owner_id   = ID_FLD_W'(next_owner_id);
         end else begin
            r.status = ST_NOFIT;
         end
      end
      return r;
   endfunction

   // offer one request in bursts, predict its response once accepted
   task automatic send_request(input logic mode, input logic [SIZE_W-1:0] size,
                               input policy_type policy, input logic [ID_FLD_W-1:0] rel);
      int gap;
      int i;
      @(negedge clock);
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      burst_left--;
      req_valid        <= 1'b1;
      req_mode         <= mode;
      req_request_size <= size;
      req_policy       <= policy;
      req_release_id   <= rel;
      do @(posedge clock); while (req_stall);
      last_reply = predict_reply(mode, size, policy, rel);
      pending_replies.push_back(last_reply);
      total_requests++;
      // track live owners so releases mostly hit real blocks
      if (mode == MODE_RELEASE) begin
         release_count++;
         freed_total += last_reply.freed_units;
         if (last_reply.freed_units != 0 || managed_size >= MEM_UNITS_DEF) begin
            for (i = 0; i < live_owners.size(); i++) begin
               if (live_owners[i] == rel) begin
                  live_owners.delete(i);
                  break;
               end
            end
         end
      end else begin
         case (last_reply.status)
            ST_OK: begin
               grant_count++;
               live_owners.push_back(last_reply.owner_id);
            end
            ST_NOFIT:  nofit_count++;
            ST_POLICY: policy_reject_count++;
            default:   exhausted_count++;
         endcase
      end
   endtask

   task automatic request_alloc(input logic [SIZE_W-1:0] size, input policy_type policy);
      send_request(MODE_ALLOC, size, policy, ID_FLD_W'($urandom_range(0, 255)));
   endtask

   task automatic request_release(input logic [ID_FLD_W-1:0] rel);
      send_request(MODE_RELEASE, SIZE_W'($urandom_range(0, 511)),
                   policy_type'($urandom_range(0, 3)), rel);
   endtask

   // sender pauses until every response is back and the block settles
   task automatic drain_responses();
      @(negedge clock);
      req_valid <= 1'b0;
      burst_left = 0;
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic program_memory_size(input logic [MSIZE_W-1:0] value);
      drain_responses();
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      managed_size = value;
   endtask

   // only valid with the full map managed, else outside owners never leave
   task automatic release_all_owners();
      while (live_owners.size() != 0) request_release(live_owners[0]);
   endtask

   // field extremes, every policy, zero size, full map, hole choice
   task automatic test_directed_fits();
      logic [7:0] id_full;
      logic [7:0] id_a;
      logic [7:0] id_c;
      logic [7:0] id_f;
      request_release(8'd0);
      request_release(8'hFF);
      request_alloc(9'd0, POL_FIRST);
      request_alloc(9'd256, POL_FIRST);
      id_full = last_reply.owner_id;
      // map full: even a zero size finds no run
      request_alloc(9'd0, POL_BEST);
      request_alloc(9'd1, POL_INVALID);
      request_release(id_full);
      request_alloc(9'd511, POL_WORST);
      request_alloc(9'd257, POL_FIRST);
      // carve holes of 10, 20 and 6 units ahead of the big tail run
      request_alloc(9'd10, POL_FIRST);
      id_a = last_reply.owner_id;
      request_alloc(9'd3, POL_FIRST);
      request_alloc(9'd20, POL_FIRST);
      id_c = last_reply.owner_id;
      request_alloc(9'd3, POL_FIRST);
      request_alloc(9'd6, POL_FIRST);
      id_f = last_reply.owner_id;
      request_alloc(9'd2, POL_FIRST);
      request_release(id_a);
      request_release(id_c);
      request_release(id_f);
      request_alloc(9'd5, POL_FIRST);
      request_alloc(9'd5, POL_BEST);
      request_alloc(9'd6, POL_BEST);
      request_alloc(9'd7, POL_WORST);
      request_alloc(9'd20, POL_BEST);
      // worst fit picks the largest run, which is too short here
      request_alloc(9'd213, POL_WORST);
   endtask

   // zero, one, oversized and shrunk memory sizes
   task automatic test_memory_sizes();
      logic [7:0] id_small;
      logic [7:0] id_wide;
      release_all_owners();
      program_memory_size(9'd0);
      request_alloc(9'd0, POL_FIRST);
      request_alloc(9'd1, POL_WORST);
      request_release(8'd1);
      program_memory_size(9'd1);
      request_alloc(9'd1, POL_BEST);
      id_small = last_reply.owner_id;
      request_alloc(9'd0, POL_FIRST);
      program_memory_size(9'd511);
      request_alloc(9'd255, POL_WORST);
      id_wide = last_reply.owner_id;
      // shrink: units above the window keep their owner
      program_memory_size(9'd4);
      request_release(id_wide);
      request_alloc(9'd2, POL_FIRST);
      request_release(id_small);
      program_memory_size(9'd256);
      request_alloc(9'd1, POL_BEST);
      request_release(id_wide);
      release_all_owners();
   endtask

   // long receiver hold-off while requests keep coming, then a full drain
   task automatic test_backpressure();
      int n;
      program_memory_size(9'd32);
      hold_off_pending = 1'b1;
      for (n = 0; n < 14; n++) begin
         if (n % 3 == 2 && live_owners.size() != 0)
            request_release(live_owners[0]);
         else
            request_alloc(SIZE_W'($urandom_range(1, 4)), policy_type'($urandom_range(0, 2)));
      end
      drain_responses();
   endtask

   // mixed traffic over several memory sizes
   task automatic test_random_traffic();
      int              phase_sizes [6];
      int              p;
      int              n;
      int              units;
      int              pick;
      int              kind;
      policy_type      pol;
      logic [SIZE_W-1:0]   size;
      logic [ID_FLD_W-1:0] rel;
      phase_sizes = '{256, 40, 8, 511, 96, 255};
      for (p = 0; p < 6; p++) begin
         program_memory_size(MSIZE_W'(phase_sizes[p]));
         units = (phase_sizes[p] < MEM_UNITS_DEF) ? phase_sizes[p] : MEM_UNITS_DEF;
         for (n = 0; n < ITEMS_PER_PHASE; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 42) begin
               kind = $urandom_range(0, 99);
               pol  = (kind < 6) ? POL_INVALID : policy_type'($urandom_range(0, 2));
               kind = $urandom_range(0, 99);
               if (kind < 6)
                  size = SIZE_W'($urandom_range(0, 511));
               else if (kind < 12)
                  size = '0;
               else
                  size = SIZE_W'($urandom_range(1, units / 4 + 1));
               request_alloc(size, pol);
            end else begin
               kind = $urandom_range(0, 99);
               if (kind < 80 && live_owners.size() != 0)
                  rel = live_owners[$urandom_range(0, live_owners.size() - 1)];
               else if (kind < 90)
                  rel = '0;
               else
                  rel = ID_FLD_W'($urandom_range(1, 255));
               request_release(rel);
            end
         end
      end
   endtask

   // use up the id counter, then check it sticks at its top value
   task automatic test_id_exhaustion();
      int guard;
      guard = 0;
      program_memory_size(9'd256);
      while (next_owner_id < ID_LIMIT && guard < 300) begin
         request_alloc(SIZE_W'($urandom_range(1, 3)), policy_type'($urandom_range(0, 2)));
         guard++;
      end
      request_alloc(9'd1, POL_FIRST);
      request_alloc(9'd0, POL_BEST);
      request_alloc(9'd256, POL_WORST);
      // policy is checked ahead of the id counter
      request_alloc(9'd1, POL_INVALID);
      release_all_owners();
   endtask

   // receiver stall driver with its own hold-off counter
   always @(negedge clock) begin
      if (hold_off_pending) begin
         hold_off_pending = 1'b0;
         hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         if (pattern_left == 0) begin
            stall_pattern = stall_pattern_type'($urandom_range(0, 3));
            pattern_left  = $urandom_range(40, 300);
         end
         pattern_left--;
         stall_phase++;
         case (stall_pattern)
            STALL_NONE:  rsp_stall <= 1'b0;
            STALL_LIGHT: rsp_stall <= ($urandom_range(0, 99) < 20);
            STALL_HEAVY: rsp_stall <= ($urandom_range(0, 99) < 70);
            default:     rsp_stall <= ((stall_phase % 7) < 3);
         endcase
      end
   end

   // response checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_replies.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("cycle %0d: unexpected response status %0d start %0d owner %0d freed %0d",
                        cycle_count, rsp_status, rsp_start_unit, rsp_owner_id,
                        rsp_freed_units);
         end else begin
            expected_reply = pending_replies.pop_front();
            if (rsp_status !== expected_reply.status ||
                rsp_start_unit !== expected_reply.start_unit ||
                rsp_owner_id !== expected_reply.owner_id ||
                rsp_freed_units !== expected_reply.freed_units) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display({"cycle %0d: expected status %0d start %0d owner %0d freed %0d, ",
                            "got status %0d start %0d owner %0d freed %0d"},
                           cycle_count, expected_reply.status, expected_reply.start_unit,
                           expected_reply.owner_id, expected_reply.freed_units,
                           rsp_status, rsp_start_unit, rsp_owner_id, rsp_freed_units);
            end
         end
      end
   end

   // test sequence
   initial begin
      foreach (owner_map[u]) owner_map[u] = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed_fits();
      test_memory_sizes();
      test_backpressure();
      test_random_traffic();
      test_id_exhaustion();
      drain_responses();
      $display({"summary: %0d requests, %0d grants, %0d fit misses, ",
                "%0d bad policy, %0d past id limit"},
               total_requests, grant_count, nofit_count, policy_reject_count, exhausted_count);
      $display("summary: %0d releases cleared %0d units, memory sizes 0 to 511, %0d mismatches",
               release_count, freed_total, mismatch_count);
      if (mismatch_count == 0 && pending_replies.size() == 0)
         $display("tb_contiguous_fit_allocator_unit passed");
      else
         $display("tb_contiguous_fit_allocator_unit failed");
      $finish;
   end

endmodule

// File: files.f
rtl/cfa_pkg.sv
rtl/cfa_ram.sv
rtl/cfa_fit_unit.sv
rtl/contiguous_fit_allocator_unit.sv
verif/tb_contiguous_fit_allocator_unit.sv
